/* hdl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// shared constants and types of the local threshold binarizer
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int MAX_WIN    = 31;
    localparam int MAX_LINE   = 2048;
    localparam int SLOT_W     = 5;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int LINE_AW    = SLOT_W + COL_W;
    localparam int LINE_DEPTH = 2 ** LINE_AW;
    localparam int CS_W       = 13;
    localparam int CSS_W      = 21;
    localparam int WS_W       = 18;
    localparam int WQ_W       = 26;
    localparam int COLM_W     = CS_W + CSS_W;

    localparam logic [1:0] CFG_WIN_SIZE   = 2'd0;
    localparam logic [1:0] CFG_K_GAIN     = 2'd1;
    localparam logic [1:0] CFG_R_NORM     = 2'd2;
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd3;

    localparam logic [4:0]  WIN_SIZE_RST   = 5'd15;
    localparam logic [15:0] K_GAIN_RST     = 16'd819;
    localparam logic [15:0] R_NORM_RST     = 16'd16384;
    localparam logic [11:0] LINE_WIDTH_RST = 12'd526;

    localparam logic [7:0] PIX_DARK  = 8'd0;
    localparam logic [7:0] PIX_LIGHT = 8'd255;

    typedef struct packed {
        logic               start;
        logic [4:0]         n;
        logic [WS_W-1:0]    s;
        logic [WQ_W-1:0]    q;
        logic [7:0]         centre;
        logic signed [15:0] k;
        logic [15:0]        rr;
    } thr_req_t;

endpackage

`default_nettype wire

/* hdl/slt_ram.sv */
// ----------------------------------------------------------------------------
// slt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/slt_thresh.sv */
// ----------------------------------------------------------------------------
// slt_thresh
// window statistics to threshold decision: variance, bit serial square root,
// bit serial divide for std/R, gain factor and final compare
// ----------------------------------------------------------------------------
`default_nettype none

module slt_thresh (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire slt_pkg::thr_req_t req,
    output logic                   done,
    output logic                   dark
);

    typedef enum logic [3:0] {
        T_IDLE, T_MUL0, T_MUL1, T_MUL2, T_SQRT, T_DIV, T_MULK, T_FACT, T_MULS, T_CMP
    } tstate_t;

    tstate_t state_reg;

    logic [slt_pkg::WS_W-1:0] s_reg;
    logic [slt_pkg::WQ_W-1:0] q_reg;
    logic [7:0]               cen_reg;
    logic [4:0]               n_reg;
    logic signed [15:0]       k_reg;
    logic [15:0]              rr_reg;
    logic [9:0]               nn_reg;
    logic [35:0]              a_reg;
    logic [35:0]              b_reg;
    logic [17:0]              cn_reg;
    logic [17:0]              m_reg;
    logic [33:0]              den_reg;
    logic [51:0]              vsh_reg;
    logic [28:0]              srem_reg;
    logic [25:0]              root_reg;
    logic [48:0]              numsh_reg;
    logic [34:0]              drem_reg;
    logic [48:0]              quo_reg;
    logic [5:0]               cnt_reg;
    logic signed [49:0]       p_reg;
    logic signed [38:0]       f_reg;
    logic [37:0]              lo_reg;
    logic signed [37:0]       hi_reg;
    logic                     done_reg;
    logic                     dark_reg;

    logic [28:0]        sr;
    logic [28:0]        trial;
    logic [28:0]        srem_nx;
    logic [25:0]        root_nx;
    logic [34:0]        dr;
    logic [34:0]        drem_nx;
    logic               qbit;
    logic [32:0]        ratio;
    logic signed [33:0] u_s;
    logic signed [18:0] s_sx;
    logic signed [18:0] f_hi;
    logic signed [57:0] prod;
    logic signed [57:0] lim;

    always_comb
    begin
        sr    = {srem_reg[26:0], vsh_reg[51:50]};
        trial = {1'b0, root_reg, 2'b01};
        if (sr >= trial)
        begin
            srem_nx = sr - trial;
            root_nx = {root_reg[24:0], 1'b1};
        end
        else
        begin
            srem_nx = sr;
            root_nx = {root_reg[24:0], 1'b0};
        end

        dr = {drem_reg[33:0], numsh_reg[48]};
        if (dr >= {1'b0, den_reg})
        begin
            drem_nx = dr - {1'b0, den_reg};
            qbit    = 1'b1;
        end
        else
        begin
            drem_nx = dr;
            qbit    = 1'b0;
        end

        ratio = (quo_reg > 49'h1_0000_0000) ? 33'h1_0000_0000 : quo_reg[32:0];
        u_s   = $signed({1'b0, ratio}) - 34'sd65536;
        s_sx  = $signed({1'b0, s_reg});
        f_hi  = f_reg[38:20];
        prod  = (58'(hi_reg) <<< 20) + $signed({20'd0, lo_reg});
        lim   = $signed({24'd0, cn_reg, 16'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
            dark_reg  <= 1'b0;
            s_reg     <= '0;
            q_reg     <= '0;
            cen_reg   <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            rr_reg    <= '0;
            nn_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            cn_reg    <= '0;
            m_reg     <= '0;
            den_reg   <= '0;
            vsh_reg   <= '0;
            srem_reg  <= '0;
            root_reg  <= '0;
            numsh_reg <= '0;
            drem_reg  <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            p_reg     <= '0;
            f_reg     <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (req.start)
                    begin
                        s_reg     <= req.s;
                        q_reg     <= req.q;
                        cen_reg   <= req.centre;
                        n_reg     <= req.n;
                        k_reg     <= req.k;
                        rr_reg    <= req.rr;
                        state_reg <= T_MUL0;
                    end
                end
                T_MUL0:
                begin
                    nn_reg    <= 10'(n_reg * n_reg);
                    state_reg <= T_MUL1;
                end
                T_MUL1:
                begin
                    a_reg     <= 36'(nn_reg * q_reg);
                    b_reg     <= 36'(s_reg * s_reg);
                    cn_reg    <= 18'(cen_reg * nn_reg);
                    m_reg     <= 18'(nn_reg * 8'd255);
                    state_reg <= T_MUL2;
                end
                T_MUL2:
                begin
                    vsh_reg   <= {((a_reg > b_reg) ? a_reg - b_reg : 36'd0), 16'd0};
                    den_reg   <= 34'(m_reg * rr_reg);
                    srem_reg  <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= 6'd25;
                    state_reg <= T_SQRT;
                end
                T_SQRT:
                begin
                    srem_reg <= srem_nx;
                    root_reg <= root_nx;
                    vsh_reg  <= {vsh_reg[49:0], 2'b00};
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        numsh_reg <= {root_nx, 23'd0};
                        drem_reg  <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= 6'd48;
                        state_reg <= T_DIV;
                    end
                end
                T_DIV:
                begin
                    drem_reg  <= drem_nx;
                    quo_reg   <= {quo_reg[47:0], qbit};
                    numsh_reg <= {numsh_reg[47:0], 1'b0};
                    cnt_reg   <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= T_MULK;
                    end
                end
                T_MULK:
                begin
                    p_reg     <= k_reg * u_s;
                    state_reg <= T_FACT;
                end
                T_FACT:
                begin
                    f_reg     <= 39'(p_reg >>> 12) + 39'sd65536;
                    state_reg <= T_MULS;
                end
                T_MULS:
                begin
                    lo_reg    <= 38'(s_reg * f_reg[19:0]);
                    hi_reg    <= s_sx * f_hi;
                    state_reg <= T_CMP;
                end
                T_CMP:
                begin
                    dark_reg  <= (prod < lim);
                    done_reg  <= 1'b1;
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign dark = dark_reg;

endmodule

`default_nettype wire

/* hdl/sauvola_local_threshold_core.sv */
// ----------------------------------------------------------------------------
// sauvola_local_threshold_core
// streaming local threshold binarizer over an odd n-by-n window
// ----------------------------------------------------------------------------
// Pixels of a padded grey image enter in raster order; one binarized item
// leaves per complete window. Pixel history and per-column sums live in two
// rams with registered read ports; each item does a read, modify and
// write-back of its column. An item that gives no result passes through the
// row-slot remainder, then two ram reads and the write-back; an item with a
// result then goes through the threshold unit, dominated by the 26-step
// square root and the 49-step divide, and a hand-over of the result, plus
// any wait for out_ready. After reset a clearing pass over 65536 addresses
// zeroes the rams while no item is taken; configuration writes are
// taken at any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sauvola_local_threshold_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_pixel,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_pixel,
    output logic [11:0]      out_row,
    output logic [10:0]      out_col
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MOD, ST_RD1, ST_RD2, ST_WB, ST_THR, ST_OUT
    } state_t;

    state_t state_reg;

    logic [4:0]                      win_size_reg;
    logic [15:0]                     k_gain_reg;
    logic [15:0]                     r_norm_reg;
    logic [11:0]                     line_width_reg;
    logic [slt_pkg::LINE_AW-1:0]     clr_reg;
    logic [slt_pkg::ROW_W-1:0]       row_reg;
    logic [slt_pkg::COL_W-1:0]       col_reg;
    logic [slt_pkg::ROW_W-1:0]       r_reg;
    logic [slt_pkg::COL_W-1:0]       c_reg;
    logic [7:0]                      px_reg;
    logic [slt_pkg::ROW_W-1:0]       msh_a_reg;
    logic [slt_pkg::ROW_W-1:0]       msh_b_reg;
    logic [slt_pkg::SLOT_W-1:0]      slot_a_reg;
    logic [slt_pkg::SLOT_W-1:0]      slot_b_reg;
    logic [3:0]                      mcnt_reg;
    logic [7:0]                      old_reg;
    logic [slt_pkg::COLM_W-1:0]      colv_reg;
    logic [slt_pkg::WS_W-1:0]        ws_reg;
    logic [slt_pkg::WQ_W-1:0]        wq_reg;
    logic                            out_valid_reg;
    logic [7:0]                      out_pixel_reg;
    logic [11:0]                     out_row_reg;
    logic [10:0]                     out_col_reg;

    logic [4:0]                      win_or;
    logic [4:0]                      n_eff;
    logic [4:0]                      nm1;
    logic [4:0]                      pad;
    logic [11:0]                     w_eff;
    logic [15:0]                     rr_eff;
    logic [slt_pkg::ROW_W-1:0]       r_in;
    logic [slt_pkg::COL_W-1:0]       c_in;
    logic [11:0]                     c_inc;
    logic [5:0]                      ta;
    logic [5:0]                      tb;
    logic [5:0]                      ra;
    logic [5:0]                      rb;

    logic [slt_pkg::CS_W-1:0]        cs_base;
    logic [slt_pkg::CSS_W-1:0]       css_base;
    logic [15:0]                     px2;
    logic [15:0]                     old2;
    logic [slt_pkg::CS_W-1:0]        cs_new;
    logic [slt_pkg::CSS_W-1:0]       css_new;
    logic [slt_pkg::WS_W-1:0]        ws_new;
    logic [slt_pkg::WQ_W-1:0]        wq_new;
    logic                            emit;

    logic                            line_we;
    logic [slt_pkg::LINE_AW-1:0]     line_waddr;
    logic [7:0]                      line_wdata;
    logic [slt_pkg::LINE_AW-1:0]     line_raddr;
    logic [7:0]                      line_rdata;
    logic                            col_we;
    logic [slt_pkg::COL_W-1:0]       col_waddr;
    logic [slt_pkg::COLM_W-1:0]      col_wdata;
    logic [slt_pkg::COL_W-1:0]       col_raddr;
    logic [slt_pkg::COLM_W-1:0]      col_rdata;

    slt_pkg::thr_req_t               thr_req;
    logic                            thr_done;
    logic                            thr_dark;

    // effective configuration
    always_comb
    begin
        win_or = win_size_reg | 5'd1;
        n_eff  = (win_or == 5'd1) ? 5'd3 : win_or;
        nm1    = n_eff - 5'd1;
        pad    = n_eff >> 1;
        if (line_width_reg == 12'd0)
        begin
            w_eff = 12'd1;
        end
        else if (line_width_reg > 12'(slt_pkg::MAX_LINE))
        begin
            w_eff = 12'(slt_pkg::MAX_LINE);
        end
        else
        begin
            w_eff = line_width_reg;
        end
        rr_eff = (r_norm_reg == 16'd0) ? 16'd1 : r_norm_reg;
    end

    // position of the arriving item
    always_comb
    begin
        if (frame_start)
        begin
            r_in = '0;
            c_in = '0;
        end
        else if ({1'b0, col_reg} >= w_eff)
        begin
            r_in = row_reg + 12'd1;
            c_in = '0;
        end
        else
        begin
            r_in = row_reg;
            c_in = col_reg;
        end
        c_inc = {1'b0, c_in} + 12'd1;
    end

    // row slot remainder, one bit per cycle
    always_comb
    begin
        ta = {slot_a_reg, msh_a_reg[11]};
        tb = {slot_b_reg, msh_b_reg[11]};
        ra = (ta >= {1'b0, n_eff}) ? ta - {1'b0, n_eff} : ta;
        rb = (tb >= {1'b0, n_eff}) ? tb - {1'b0, n_eff} : tb;
    end

    // column and window update
    always_comb
    begin
        cs_base  = (r_reg == '0) ? '0 : colv_reg[slt_pkg::COLM_W-1:slt_pkg::CSS_W];
        css_base = (r_reg == '0) ? '0 : colv_reg[slt_pkg::CSS_W-1:0];
        px2      = 16'(px_reg * px_reg);
        old2     = 16'(old_reg * old_reg);
        cs_new   = cs_base + {5'd0, px_reg};
        css_new  = css_base + {5'd0, px2};
        if (r_reg >= {7'd0, n_eff})
        begin
            cs_new  = cs_new - {5'd0, old_reg};
            css_new = css_new - {5'd0, old2};
        end
        if (c_reg == '0)
        begin
            ws_new = {5'd0, cs_new};
            wq_new = {5'd0, css_new};
        end
        else
        begin
            ws_new = ws_reg + {5'd0, cs_new};
            wq_new = wq_reg + {5'd0, css_new};
            if (c_reg >= {6'd0, n_eff})
            begin
                ws_new = ws_new - {5'd0, col_rdata[slt_pkg::COLM_W-1:slt_pkg::CSS_W]};
                wq_new = wq_new - {5'd0, col_rdata[slt_pkg::CSS_W-1:0]};
            end
        end
        emit = (r_reg >= {7'd0, nm1}) && (c_reg >= {6'd0, nm1});
    end

    // ram ports
    always_comb
    begin
        line_raddr = (state_reg == ST_RD1) ? {slot_a_reg, c_reg}
                                           : {slot_b_reg, c_reg - {6'd0, pad}};
        col_raddr  = (state_reg == ST_RD1) ? c_reg : c_reg - {6'd0, n_eff};
        if (state_reg == ST_CLEAR)
        begin
            line_we    = 1'b1;
            line_waddr = clr_reg;
            line_wdata = '0;
            col_we     = 1'b1;
            col_waddr  = clr_reg[slt_pkg::COL_W-1:0];
            col_wdata  = '0;
        end
        else
        begin
            line_we    = (state_reg == ST_WB);
            line_waddr = {slot_a_reg, c_reg};
            line_wdata = px_reg;
            col_we     = (state_reg == ST_WB);
            col_waddr  = c_reg;
            col_wdata  = {cs_new, css_new};
        end
    end

    always_comb
    begin
        thr_req.start  = (state_reg == ST_WB) && emit;
        thr_req.n      = n_eff;
        thr_req.s      = ws_new;
        thr_req.q      = wq_new;
        thr_req.centre = line_rdata;
        thr_req.k      = $signed(k_gain_reg);
        thr_req.rr     = rr_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            win_size_reg   <= slt_pkg::WIN_SIZE_RST;
            k_gain_reg     <= slt_pkg::K_GAIN_RST;
            r_norm_reg     <= slt_pkg::R_NORM_RST;
            line_width_reg <= slt_pkg::LINE_WIDTH_RST;
            clr_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            px_reg         <= '0;
            msh_a_reg      <= '0;
            msh_b_reg      <= '0;
            slot_a_reg     <= '0;
            slot_b_reg     <= '0;
            mcnt_reg       <= '0;
            old_reg        <= '0;
            colv_reg       <= '0;
            ws_reg         <= '0;
            wq_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_pixel_reg  <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    slt_pkg::CFG_WIN_SIZE:   win_size_reg   <= cfg_data[4:0];
                    slt_pkg::CFG_K_GAIN:     k_gain_reg     <= cfg_data;
                    slt_pkg::CFG_R_NORM:     r_norm_reg     <= cfg_data;
                    slt_pkg::CFG_LINE_WIDTH: line_width_reg <= cfg_data[11:0];
                    default:                 win_size_reg   <= win_size_reg;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + {{(slt_pkg::LINE_AW-1){1'b0}}, 1'b1};
                    if (clr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg      <= r_in;
                        c_reg      <= c_in;
                        px_reg     <= in_pixel;
                        msh_a_reg  <= r_in;
                        msh_b_reg  <= r_in - {7'd0, pad};
                        slot_a_reg <= '0;
                        slot_b_reg <= '0;
                        mcnt_reg   <= 4'd11;
                        if (c_inc >= w_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= r_in + 12'd1;
                        end
                        else
                        begin
                            col_reg <= c_inc[slt_pkg::COL_W-1:0];
                            row_reg <= r_in;
                        end
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD:
                begin
                    slot_a_reg <= ra[4:0];
                    slot_b_reg <= rb[4:0];
                    msh_a_reg  <= {msh_a_reg[10:0], 1'b0};
                    msh_b_reg  <= {msh_b_reg[10:0], 1'b0};
                    mcnt_reg   <= mcnt_reg - 4'd1;
                    if (mcnt_reg == 4'd0)
                    begin
                        state_reg <= ST_RD1;
                    end
                end
                ST_RD1:
                begin
                    state_reg <= ST_RD2;
                end
                ST_RD2:
                begin
                    old_reg   <= line_rdata;
                    colv_reg  <= col_rdata;
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    ws_reg    <= ws_new;
                    wq_reg    <= wq_new;
                    state_reg <= emit ? ST_THR : ST_IDLE;
                end
                ST_THR:
                begin
                    if (thr_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pixel_reg <= thr_dark ? slt_pkg::PIX_DARK : slt_pkg::PIX_LIGHT;
                        out_row_reg   <= r_reg - {7'd0, nm1};
                        out_col_reg   <= c_reg - {6'd0, nm1};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    slt_ram #(
        .WIDTH (8),
        .DEPTH (slt_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    slt_ram #(
        .WIDTH (slt_pkg::COLM_W),
        .DEPTH (slt_pkg::MAX_LINE)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    slt_thresh u_thresh (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (thr_req),
        .done  (thr_done),
        .dark  (thr_dark)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

endmodule

`default_nettype wire
